// File: hw/rtl/sjm_pkg.sv
// Shared types and constants for the station Jones matrix pipeline.
`timescale 1ns / 1ps
package sjm_pkg;

   localparam int ANGLE_W = 16;
   localparam int GAIN_W  = 16;
   localparam int ENTRY_W = 18;
   localparam int TRIG_W  = 16;
   localparam int QX_W    = 15;   // first-quadrant argument, 0..16384
   localparam int POLY_W  = 31;   // Horner partial sum, Q30
   localparam int PROD_W  = 30;   // trig products, Q28
   localparam int SUM_W   = 46;   // matrix entries, Q42
   localparam int LO_W    = 22;   // low split of a matrix entry
   localparam int HI_W    = SUM_W - LO_W;
   localparam int FULL_W  = 64;

   localparam logic [POLY_W-1:0] SIN_C1 = 31'd1686629713;
   localparam logic [POLY_W-1:0] SIN_C3 = 31'd693598668;
   localparam logic [POLY_W-1:0] SIN_C5 = 31'd85569306;
   localparam logic [POLY_W-1:0] SIN_C7 = 31'd5026995;
   localparam logic [POLY_W-1:0] SIN_C9 = 31'd172272;

   localparam logic [QX_W-1:0] QUARTER = 15'd16384;

   localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 18'sd131071;
   localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -18'sd131072;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [GAIN_W-1:0] gain_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;

endpackage

// File: hw/rtl/station_jones_matrix_core.sv
// Station Jones matrix core: trig, matrix product, gain scaling, rounding.
//
// One transaction on the req_ channel carries a grid cell: three angles
// (unsigned fractions of a turn) and two complex Q1.14 gains. For each one
// the core returns one transaction on the rsp_ channel with the four complex
// Jones entries in Q3.14, rounded half up and saturated to 18 bits.
//
// Twelve register stages; the accepting edge loads the first and rsp_valid
// rises when the cell reaches the last. One cell per clock can be accepted
// unless rsp_stall holds the pipeline. The depth is set by the quadrant
// fold, the sine polynomial (six dependent multiplies), the trig rounding,
// three multiply stages of the matrix and gain product and one rounding stage.
//
// reset (synchronous, active high) clears all valid bits; results in
// flight are dropped. When rsp_stall is high while a result is shown, the
// whole pipeline holds and req_stall is raised; nothing is lost or repeated.
// Bubbles in the pipeline advance freely while the output is empty.
`timescale 1ns / 1ps
module station_jones_matrix_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_faraday_angle,
   input  logic [15:0]            req_dipole_angle,
   input  logic [15:0]            req_ellipticity_angle,
   input  sjm_pkg::gain_type      req_gain_one_re,
   input  sjm_pkg::gain_type      req_gain_one_im,
   input  sjm_pkg::gain_type      req_gain_two_re,
   input  sjm_pkg::gain_type      req_gain_two_im,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sjm_pkg::entry_type     rsp_entry_aa_re,
   output sjm_pkg::entry_type     rsp_entry_aa_im,
   output sjm_pkg::entry_type     rsp_entry_ab_re,
   output sjm_pkg::entry_type     rsp_entry_ab_im,
   output sjm_pkg::entry_type     rsp_entry_ba_re,
   output sjm_pkg::entry_type     rsp_entry_ba_im,
   output sjm_pkg::entry_type     rsp_entry_bb_re,
   output sjm_pkg::entry_type     rsp_entry_bb_im
);
   import sjm_pkg::*;

   localparam int NSTG = 12;

   // trig lanes: 0 sf, 1 cf, 2 sr, 3 cr, 4 se, 5 ce
   logic                    vld_ff [NSTG];
   logic [QX_W-1:0]         x_ff   [6][6];
   logic                    neg_ff [7][6];
   logic [QX_W-1:0]         x2_ff  [1:4][6];
   logic [POLY_W-1:0]       p_ff   [2:5][6];
   logic [31:0]             s_ff   [6];
   trig_type                trig_ff[6];
   gain_type                g_ff   [10][4];
   logic signed [PROD_W-1:0] cc_ff, ss_ff, cs_ff, sc_ff;
   trig_type                cf_ff, sf_ff;
   logic signed [SUM_W-1:0] m_ff   [8];
   logic signed [HI_W+GAIN_W-1:0] ph_ff [8][2];
   logic signed [LO_W+GAIN_W:0]   pl_ff [8][2];
   entry_type               out_ff [8];

   logic                    adv;
   logic [ANGLE_W-1:0]      ang    [3];
   gain_type                gin    [4];

   function automatic logic [31:0] hmul(input logic [POLY_W-1:0] p,
                                        input logic [QX_W-1:0] x2);
      logic [POLY_W+QX_W-1:0] pr;
      pr = p * x2;
      return pr[POLY_W+QX_W-1:14];
   endfunction

   function automatic logic [POLY_W-1:0] hstep(input logic [POLY_W-1:0] c,
                                                input logic [POLY_W-1:0] p,
                                                input logic [QX_W-1:0] x2);
      logic [31:0] d;
      d = {1'b0, c} - hmul(p, x2);
      return d[POLY_W-1:0];
   endfunction

   function automatic trig_type trig_fin(input logic [31:0] s, input logic neg);
      logic [32:0] t;
      logic [16:0] q;
      logic [TRIG_W-1:0] v;
      t = {1'b0, s} + 33'd32768;
      q = t[32:16];
      v = (q > 17'd16384) ? TRIG_W'(16384) : q[TRIG_W-1:0];
      return neg ? trig_type'(-v) : trig_type'(v);
   endfunction

   function automatic entry_type round_sat(input logic signed [HI_W+GAIN_W:0] hi,
                                           input logic signed [LO_W+GAIN_W+1:0] lo);
      logic signed [FULL_W-1:0] tot;
      logic signed [FULL_W-1:0] r;
      tot = (FULL_W'(hi) <<< LO_W) + FULL_W'(lo) + (FULL_W'(1) <<< 41);
      r = tot >>> 42;
      if (r > FULL_W'(ENTRY_MAX))
         return ENTRY_MAX;
      else if (r < FULL_W'(ENTRY_MIN))
         return ENTRY_MIN;
      return r[ENTRY_W-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] prod(input logic signed [PROD_W-1:0] a,
                                                    input trig_type b);
      return SUM_W'(a * b);
   endfunction

   assign adv       = !(vld_ff[NSTG-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NSTG-1];

   assign ang[0] = req_faraday_angle;
   assign ang[1] = req_dipole_angle;
   assign ang[2] = req_ellipticity_angle;
   assign gin[0] = req_gain_one_re;
   assign gin[1] = req_gain_one_im;
   assign gin[2] = req_gain_two_re;
   assign gin[3] = req_gain_two_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < NSTG; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // quadrant fold; cosine is the sine one quarter turn on
         for (int k = 0; k < 6; k++) begin
            logic [1:0] quad;
            logic [QX_W-1:0] r;
            quad = ang[k/2][15:14] + ((k % 2 == 1) ? 2'd1 : 2'd0);
            r = {1'b0, ang[k/2][13:0]};
            x_ff[0][k]   <= quad[0] ? (QUARTER - r) : r;
            neg_ff[0][k] <= quad[1];
         end
         for (int j = 0; j < 4; j++) g_ff[0][j] <= gin[j];
         for (int s = 1; s < 10; s++)
            for (int j = 0; j < 4; j++) g_ff[s][j] <= g_ff[s-1][j];
         for (int s = 1; s < 6; s++)
            for (int k = 0; k < 6; k++) x_ff[s][k] <= x_ff[s-1][k];
         for (int s = 1; s < 7; s++)
            for (int k = 0; k < 6; k++) neg_ff[s][k] <= neg_ff[s-1][k];

         for (int k = 0; k < 6; k++) begin
            logic [2*QX_W-1:0] sq;
            logic [POLY_W+QX_W-1:0] sp;
            sq = x_ff[0][k] * x_ff[0][k];
            x2_ff[1][k] <= sq[2*QX_W-2:14];
            for (int s = 2; s < 5; s++) x2_ff[s][k] <= x2_ff[s-1][k];
            p_ff[2][k] <= hstep(SIN_C7, SIN_C9, x2_ff[1][k]);
            p_ff[3][k] <= hstep(SIN_C5, p_ff[2][k], x2_ff[2][k]);
            p_ff[4][k] <= hstep(SIN_C3, p_ff[3][k], x2_ff[3][k]);
            p_ff[5][k] <= hstep(SIN_C1, p_ff[4][k], x2_ff[4][k]);
            sp = p_ff[5][k] * x_ff[5][k];
            s_ff[k]    <= sp[45:14];
            trig_ff[k] <= trig_fin(s_ff[k], neg_ff[6][k]);
         end

         cc_ff <= PROD_W'(trig_ff[5] * trig_ff[3]);
         ss_ff <= PROD_W'(trig_ff[4] * trig_ff[2]);
         cs_ff <= PROD_W'(trig_ff[5] * trig_ff[2]);
         sc_ff <= PROD_W'(trig_ff[4] * trig_ff[3]);
         cf_ff <= trig_ff[1];
         sf_ff <= trig_ff[0];

         m_ff[0] <= prod(cc_ff, cf_ff) - prod(cs_ff, sf_ff);
         m_ff[1] <= prod(sc_ff, sf_ff) - prod(ss_ff, cf_ff);
         m_ff[2] <= -prod(cs_ff, cf_ff) - prod(cc_ff, sf_ff);
         m_ff[3] <= prod(sc_ff, cf_ff) + prod(ss_ff, sf_ff);
         m_ff[4] <= prod(cs_ff, cf_ff) + prod(cc_ff, sf_ff);
         m_ff[5] <= prod(sc_ff, cf_ff) + prod(ss_ff, sf_ff);
         m_ff[6] <= prod(cc_ff, cf_ff) - prod(cs_ff, sf_ff);
         m_ff[7] <= prod(ss_ff, cf_ff) - prod(sc_ff, sf_ff);

         // gain product, each matrix entry split in two halves
         for (int e = 0; e < 4; e++) begin
            gain_type gr, gi;
            logic signed [SUM_W-1:0] mr, mi;
            gr = (e < 2) ? g_ff[9][0] : g_ff[9][2];
            gi = (e < 2) ? g_ff[9][1] : g_ff[9][3];
            mr = m_ff[2*e];
            mi = m_ff[2*e+1];
            ph_ff[2*e][0]   <= gr * $signed(mr[SUM_W-1:LO_W]);
            ph_ff[2*e][1]   <= gi * $signed(mi[SUM_W-1:LO_W]);
            pl_ff[2*e][0]   <= gr * $signed({1'b0, mr[LO_W-1:0]});
            pl_ff[2*e][1]   <= gi * $signed({1'b0, mi[LO_W-1:0]});
            ph_ff[2*e+1][0] <= gr * $signed(mi[SUM_W-1:LO_W]);
            ph_ff[2*e+1][1] <= gi * $signed(mr[SUM_W-1:LO_W]);
            pl_ff[2*e+1][0] <= gr * $signed({1'b0, mi[LO_W-1:0]});
            pl_ff[2*e+1][1] <= gi * $signed({1'b0, mr[LO_W-1:0]});
         end

         for (int k = 0; k < 8; k++) begin
            if (k % 2 == 0)
               out_ff[k] <= round_sat(
                  (HI_W+GAIN_W+1)'(ph_ff[k][0]) - (HI_W+GAIN_W+1)'(ph_ff[k][1]),
                  (LO_W+GAIN_W+2)'(pl_ff[k][0]) - (LO_W+GAIN_W+2)'(pl_ff[k][1]));
            else
               out_ff[k] <= round_sat(
                  (HI_W+GAIN_W+1)'(ph_ff[k][0]) + (HI_W+GAIN_W+1)'(ph_ff[k][1]),
                  (LO_W+GAIN_W+2)'(pl_ff[k][0]) + (LO_W+GAIN_W+2)'(pl_ff[k][1]));
         end
      end
   end

   assign rsp_entry_aa_re = out_ff[0];
   assign rsp_entry_aa_im = out_ff[1];
   assign rsp_entry_ab_re = out_ff[2];
   assign rsp_entry_ab_im = out_ff[3];
   assign rsp_entry_ba_re = out_ff[4];
   assign rsp_entry_ba_im = out_ff[5];
   assign rsp_entry_bb_re = out_ff[6];
   assign rsp_entry_bb_im = out_ff[7];

endmodule
